// ----- rtl/smo_pkg.sv -----
`default_nettype none
package smo_pkg;

  localparam int unsigned MaxClasses = 16;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned AccW       = 64;

  typedef enum logic [1:0] {
    MODE_LOAD_Q   = 2'd0,
    MODE_LOAD_TAU = 2'd1,
    MODE_START    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [IdxW-1:0]    row;
    logic [IdxW-1:0]    column;
    logic signed [31:0] entry_value;
    logic [IdxW-1:0]    partner_start;
  } smo_req_t;

  typedef struct packed {
    logic [IdxW-1:0]    multiplier_index;
    logic signed [31:0] multiplier_value;
    logic               converged;
    logic               last;
  } smo_rsp_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  localparam logic [2:0] RegBoxBound = 3'd0;
  localparam logic [2:0] RegTrueCls  = 3'd1;
  localparam logic [2:0] RegActSize  = 3'd2;
  localparam logic [2:0] RegTol      = 3'd3;
  localparam logic [2:0] RegIterCap  = 3'd4;

  function automatic logic signed [AccW-1:0] sat_add64(
    input logic signed [AccW-1:0] a, input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1])
      sat_add64 = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    else
      sat_add64 = s[AccW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/smo_div.sv -----
`default_nettype none
module smo_div import smo_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [AccW-1:0] num_i,
  input  wire logic signed [AccW-1:0] den_i,
  output logic                        done_o,
  output logic signed [AccW-1:0]      quo_o
);
  // restoring divider on |num|<<16, one quotient bit per cycle
  localparam int unsigned NW = AccW + 16;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]   n_q, n_d;
  logic [AccW:0]   rem_q, rem_d;
  logic [AccW-1:0] den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            neg_q, neg_d, busy_q, busy_d;
  logic [AccW:0]   trial;
  logic [AccW-1:0] mag;
  logic [NW-1:0]   absq;
  logic [AccW-1:0] resmag;

  always_comb begin
    mag   = num_i[AccW-1] ? AccW'(-num_i) : AccW'(num_i);
    n_d   = n_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    busy_d = busy_q;
    trial = {rem_q[AccW-1:0], n_q[NW-1]};
    if (start_i) begin
      n_d    = {mag, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NW);
      neg_d  = num_i[AccW-1];
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        n_d   = {n_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        n_d   = {n_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  // result of the final step is n_d; computed next cycle from n_q when done
  always_comb begin
    absq = n_q;
    if (absq[NW-1:60] != '0) resmag = AccW'(64'h1000_0000_0000_0000);
    else resmag = absq[AccW-1:0];
    quo_o = neg_q ? -$signed(resmag) : $signed(resmag);
  end
endmodule
`default_nettype wire

// ----- rtl/smo_box_qp_subproblem_solver.sv -----
`default_nettype none
// SMO box-QP solver.
// Request channel (req_valid_i/req_stall_o/req_i): load Q entries (mode 0)
// and linear terms (mode 1), one per cycle; mode 2 starts a solve.
// Response channel (rsp_valid_o/rsp_stall_i/rsp_o): on a solve, one response
// per active class, index 0 first, last set on the final one.
// A solve runs on one shared multiply-accumulate and a serial divider. The
// partner index is first reduced mod k by repeated subtraction. Each
// iteration then forms the pair sums and curvature, runs the divide only
// for a positive curvature, updates the pair, recomputes the gradients and
// takes the stop decision.
// Responses follow at one per cycle while rsp_stall_i is low.
// Requests are not taken while a solve runs or responses are pending.
// A stalled response holds; the block waits. Reset clears control state
// and presets registers; Q and linear term stores are undefined until loaded.
// APB registers at byte address 4*i: box_bound, true_class, active_size,
// tolerance, iteration_cap.
module smo_box_qp_subproblem_solver import smo_pkg::*; #(
  parameter int unsigned MAX_CLASSES = MaxClasses
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_stall_o,
  input  wire smo_req_t    req_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_stall_i,
  output smo_rsp_t         rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned K = MAX_CLASSES < 16 ? MAX_CLASSES : 16;
  localparam int unsigned KW = $clog2(K);
  localparam int unsigned SW = $clog2(K + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PREP  = 11'b00000000010,
    S_PAIR  = 11'b00000000100,
    S_DIVST = 11'b00000001000,
    S_DIVW  = 11'b00000010000,
    S_UPD   = 11'b00000100000,
    S_GRAD  = 11'b00001000000,
    S_DEC   = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_QRD   = 11'b01000000000,
    S_MOD   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [30:0] box_q;
  logic [3:0]  tcls_q;
  logic [4:0]  asz_q;
  logic [15:0] tol_q;
  logic [9:0]  cap_q;

  logic signed [31:0] qmem [1 << (2*KW)];
  logic signed [31:0] tau [K];
  logic signed [31:0] alpha_q [K];
  logic signed [31:0] qrd_q;
  logic [2*KW-1:0]    qaddr;

  logic [SW-1:0] k_q;
  logic [KW-1:0] r_q, s_q, j_q, i_q, idmx_q, idmn_q;
  logic [3:0]    ps_q;
  logic [1:0]    ph_q;  // pair phase: 0 col r,1 col s,2 diag sums
  logic [1:0]    qp_q;
  logic signed [AccW-1:0] acc_q, p_q, q_q, g_q, rmax_q, rmin_q;
  logic          hmin_q, conv_q;
  logic [9:0]    lp_q;
  logic signed [AccW-1:0] v_q;
  logic          dstart;
  logic          ddone;
  logic signed [AccW-1:0] dquo;

  smo_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(-p_q), .den_i(q_q),
    .done_o(ddone), .quo_o(dquo)
  );

  wire req_acc = req_valid_i && !req_stall_o;
  wire wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[4:2])
      RegBoxBound: prdata = {1'b0, box_q};
      RegTrueCls:  prdata = {28'd0, tcls_q};
      RegActSize:  prdata = {27'd0, asz_q};
      RegTol:      prdata = {16'd0, tol_q};
      RegIterCap:  prdata = {22'd0, cap_q};
      default:     prdata = '0;
    endcase
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_EMIT);

  logic signed [AccW-1:0] cval;
  assign cval = AccW'(box_q);  // VALUE_BITS 32 always holds 31-bit bound
  function automatic logic signed [AccW-1:0] cy(input logic [KW-1:0] x,
    input logic [3:0] tc, input logic signed [AccW-1:0] c);
    cy = (4'(x) == tc) ? c : '0;
  endfunction

  // shared multiplier operand: Q(i, col) * alpha(i)
  logic signed [AccW-1:0] prod;
  logic signed [63:0] prod_raw;
  assign prod_raw = qrd_q * alpha_q[i_q];
  assign prod = prod_raw;
  logic signed [AccW-1:0] accn;
  assign accn = sat_add64(acc_q, prod);
  logic signed [AccW-1:0] dotv;
  assign dotv = accn >>> 16;

  logic [KW-1:0] col;
  logic [KW-1:0] irow;
  always_comb begin
    col = (state_q == S_GRAD) ? j_q : ((ph_q == 2'd0) ? r_q : s_q);
    // column sums read one row ahead
    irow = (state_q == S_PAIR) ? KW'(i_q + 1'b1) : i_q;
    qaddr = {irow, col};
    if (state_q == S_PAIR && ph_q == 2'd2)
      qaddr = (qp_q == 2'd0) ? {r_q, r_q} : (qp_q == 2'd1) ? {s_q, s_q} : {r_q, s_q};
  end

  always_ff @(posedge clk_i) begin
    qrd_q <= qmem[qaddr];
    if (req_acc && req_i.mode == MODE_LOAD_Q && 32'(req_i.row) < K &&
        32'(req_i.column) < K)
      qmem[{req_i.row[KW-1:0], req_i.column[KW-1:0]}] <= req_i.entry_value;
    if (req_acc && req_i.mode == MODE_LOAD_TAU && 32'(req_i.row) < K)
      tau[req_i.row[KW-1:0]] <= req_i.entry_value;
  end

  logic signed [AccW-1:0] lt, gt, delta, nr, ns, tnext;
  always_comb begin
    lt = cy(r_q, tcls_q, cval) - AccW'(alpha_q[r_q]);
    gt = AccW'(alpha_q[s_q]) - cy(s_q, tcls_q, cval);
    if (q_q < 1) delta = (p_q >= 0) ? gt : lt;
    else if (v_q >= lt) delta = lt;
    else if (v_q <= gt) delta = gt;
    else delta = v_q;
    nr = AccW'(alpha_q[r_q]) + delta;
    ns = AccW'(alpha_q[s_q]) - delta;
    tnext = dotv + AccW'(tau[j_q]);
  end
  function automatic logic signed [31:0] satv(input logic signed [AccW-1:0] x);
    if (x > 64'sd2147483647) satv = 32'h7fffffff;
    else if (x < -64'sd2147483648) satv = 32'h80000000;
    else satv = x[31:0];
  endfunction

  logic last_i;
  assign last_i = (SW'(i_q) == k_q - 1'b1);
  assign dstart = (state_q == S_DIVST);
  logic [SW-1:0] ksel;
  always_comb begin
    ksel = (asz_q == 5'd0) ? SW'(1) : (32'(asz_q) > K) ? SW'(K) : SW'(asz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      box_q <= 31'd65536; tcls_q <= '0; asz_q <= 5'd16; tol_q <= 16'd7;
      cap_q <= 10'd200;
      for (int n = 0; n < K; n++) alpha_q[n] <= '0;
      k_q <= '0; r_q <= '0; s_q <= '0; j_q <= '0; i_q <= '0; ph_q <= '0;
      qp_q <= '0; lp_q <= '0; conv_q <= 1'b0; hmin_q <= 1'b0;
      idmx_q <= '0; idmn_q <= '0; ps_q <= '0;
      acc_q <= '0; p_q <= '0; q_q <= '0; v_q <= '0; rmax_q <= '0; rmin_q <= '0;
    end else begin
      if (wr) begin
        unique case (paddr[4:2])
          RegBoxBound: box_q  <= pwdata[30:0];
          RegTrueCls:  tcls_q <= pwdata[3:0];
          RegActSize:  asz_q  <= pwdata[4:0];
          RegTol:      tol_q  <= pwdata[15:0];
          RegIterCap:  cap_q  <= pwdata[9:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (req_acc && req_i.mode == MODE_START) begin
          for (int n = 0; n < K; n++) alpha_q[n] <= '0;
          k_q <= ksel;
          r_q <= ({1'b0, tcls_q} < 5'(ksel)) ? KW'(tcls_q) : '0;
          ps_q <= req_i.partner_start;
          lp_q <= '0; ph_q <= '0; i_q <= '0; qp_q <= '0;
          state_q <= S_MOD;
        end
        S_MOD: begin
          // partner start mod k by repeated subtraction
          if ({1'b0, ps_q} >= 5'(k_q)) begin
            ps_q <= ps_q - 4'(k_q);
          end else begin
            s_q <= KW'(ps_q);
            state_q <= S_QRD;
          end
        end
        S_QRD: begin acc_q <= '0; state_q <= S_PAIR; end
        S_PAIR: begin
          if (ph_q != 2'd2) begin
            acc_q <= accn;
            if (last_i) begin
              if (ph_q == 2'd0) p_q <= dotv + AccW'(tau[r_q]);
              else p_q <= p_q - dotv - AccW'(tau[s_q]);
              i_q <= '0; ph_q <= ph_q + 1'b1; state_q <= S_QRD;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            unique case (qp_q)
              2'd0: q_q <= '0;
              default: ;
            endcase
            if (qp_q == 2'd1) q_q <= AccW'(qrd_q);
            if (qp_q == 2'd2) q_q <= q_q + AccW'(qrd_q);
            if (qp_q == 2'd3) begin
              q_q <= q_q - 2 * AccW'(qrd_q);
              state_q <= S_DIVST;
            end
            qp_q <= qp_q + 1'b1;
          end
        end
        S_DIVST: state_q <= (q_q < 1) ? S_UPD : S_DIVW;
        S_DIVW: if (ddone) state_q <= S_DEC;
        S_DEC: begin v_q <= dquo; state_q <= S_UPD; end
        S_UPD: begin
          if (r_q != s_q) begin
            alpha_q[r_q] <= satv(nr);
            alpha_q[s_q] <= satv(ns);
          end
          lp_q <= lp_q + 1'b1;
          j_q <= '0; i_q <= '0; acc_q <= '0; hmin_q <= 1'b0;
          state_q <= S_GRAD;
        end
        S_GRAD: begin
          if (qp_q == 2'd0) begin
            qp_q <= 2'd1;  // wait for Q read
          end else begin
            if (last_i) begin
              if (j_q == '0 || tnext > rmax_q) begin rmax_q <= tnext; idmx_q <= j_q; end
              if (AccW'(alpha_q[j_q]) < cy(j_q, tcls_q, cval) &&
                  (!hmin_q || tnext < rmin_q)) begin
                rmin_q <= tnext; idmn_q <= j_q; hmin_q <= 1'b1;
              end
              acc_q <= '0; i_q <= '0; qp_q <= 2'd0;
              if (SW'(j_q) == k_q - 1'b1) begin
                j_q <= '0; state_q <= S_PREP;
              end else j_q <= j_q + 1'b1;
            end else begin
              acc_q <= accn;
              i_q <= i_q + 1'b1; qp_q <= 2'd0;
            end
          end
        end
        S_PREP: begin
          if (!hmin_q || rmin_q + $signed(AccW'(tol_q)) >= rmax_q) begin
            conv_q <= 1'b1; i_q <= '0; state_q <= S_EMIT;
          end else if (lp_q >= ((cap_q == '0) ? 10'd1 : cap_q)) begin
            conv_q <= 1'b0; i_q <= '0; state_q <= S_EMIT;
          end else begin
            r_q <= idmn_q; s_q <= idmx_q; ph_q <= '0; qp_q <= '0; i_q <= '0;
            state_q <= S_QRD;
          end
        end
        S_EMIT: if (!rsp_stall_i) begin
          if (last_i) state_q <= S_IDLE;
          else i_q <= i_q + 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp_o.multiplier_index = 4'(i_q);
    rsp_o.multiplier_value = alpha_q[i_q];
    rsp_o.converged        = conv_q;
    rsp_o.last             = last_i;
  end

  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_stall_i && !rsp_o.last |=> rsp_valid_o)
    else $error("emit broke early");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("request taken while emitting");
  a_lp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> lp_q != '0) else $error("no iteration done");
endmodule
`default_nettype wire
